[rtl/sbo_pkg.sv]
// Package with the shared types of the segment and box overlap block.
package sbo_pkg;

    localparam int NUM_AXES = 3;

    typedef struct packed {
        logic s_in;
        logic e_in;
        logic moving;
        logic en_lt1;
        logic ex_gt0;
    } lane_flags_t;

endpackage

[rtl/sbo_lane.sv]
// Per-axis slab lane: orders the corners and forms the entry and exit fractions.
module sbo_lane #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] s,
    input  logic signed [COORD_WIDTH-1:0] e,
    input  logic signed [COORD_WIDTH-1:0] ca,
    input  logic signed [COORD_WIDTH-1:0] cb,
    output logic signed [COORD_WIDTH+1:0] an,
    output logic signed [COORD_WIDTH+1:0] xn,
    output logic signed [COORD_WIDTH+1:0] dd,
    output sbo_pkg::lane_flags_t          flags
);
    import sbo_pkg::*;

    localparam int OW = COORD_WIDTH + 2;

    logic signed [OW-1:0] s_w, e_w, lo_w, hi_w, d_w;
    logic signed [OW-1:0] an_next, xn_next, dd_next;
    logic signed [OW-1:0] an_reg, xn_reg, dd_reg;
    lane_flags_t          flags_next, flags_reg;
    logic                 pos;

    always_comb
    begin
        s_w  = OW'(s);
        e_w  = OW'(e);
        lo_w = (ca < cb) ? OW'(ca) : OW'(cb);
        hi_w = (ca < cb) ? OW'(cb) : OW'(ca);
        d_w  = e_w - s_w;
        pos  = (d_w > 0);
        an_next = pos ? (lo_w - s_w) : (s_w - hi_w);
        xn_next = pos ? (hi_w - s_w) : (s_w - lo_w);
        dd_next = pos ? d_w : (-d_w);
        flags_next.s_in   = (s_w >= lo_w) && (s_w <= hi_w);
        flags_next.e_in   = (e_w >= lo_w) && (e_w <= hi_w);
        flags_next.moving = (d_w != 0);
        flags_next.en_lt1 = (an_next < dd_next);
        flags_next.ex_gt0 = (xn_next > 0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an_reg    <= an_next;
            xn_reg    <= xn_next;
            dd_reg    <= dd_next;
            flags_reg <= flags_next;
        end
    end

    assign an    = an_reg;
    assign xn    = xn_reg;
    assign dd    = dd_reg;
    assign flags = flags_reg;

endmodule

[rtl/sbo_mul.sv]
// Two-stage signed multiplier built from four half-width partial products.
module sbo_mul #(
    parameter int OW = 26
) (
    input  logic                  clk,
    input  logic                  en1,
    input  logic                  en2,
    input  logic signed [OW-1:0]  a,
    input  logic signed [OW-1:0]  b,
    output logic signed [2*OW-1:0] p
);
    import sbo_pkg::*;

    localparam int H  = OW / 2;
    localparam int HW = OW - H;
    localparam int PW = 2 * OW;

    logic signed [HW-1:0]      ah, bh;
    logic signed [H:0]         al, bl;
    logic signed [2*HW-1:0]    hh_reg;
    logic signed [HW+H:0]      hl_reg, lh_reg;
    logic signed [2*H+1:0]     ll_reg;
    logic signed [PW-1:0]      p_next, p_reg;

    always_comb
    begin
        ah = a[OW-1:H];
        bh = b[OW-1:H];
        al = $signed({1'b0, a[H-1:0]});
        bl = $signed({1'b0, b[H-1:0]});
        p_next = (PW'(hh_reg) <<< (2 * H)) + (PW'(hl_reg) <<< H)
               + (PW'(lh_reg) <<< H) + PW'(ll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            hh_reg <= ah * bh;
            hl_reg <= ah * bl;
            lh_reg <= al * bh;
            ll_reg <= al * bl;
        end
        if (en2)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

[rtl/segment_box_overlap_top.sv]
// Top level of the segment and box overlap test with three axis lanes and a merge stage.
//
// Usage: one query beat on the input channel carries a segment (start and end points)
// and two box corners, all signed fixed point. Each query gives exactly one result beat
// carrying hit, which is high when the segment touches or enters the closed box.
// Three axis lanes compute the slab entry and exit fractions in parallel. Six cross
// comparisons of entry against exit fractions run through two-stage split multipliers,
// and the merge stage combines them with the containment flags into hit.
// Throughput is one query per cycle while out_ready is high; the pipeline depth is set
// by the lane register, the partial product register, the product register and the
// output register.
// Each stage holds its beat while the next one is held full, so a stalled receiver fills
// the stages one by one and in_ready falls only when all four are occupied.
// Reset empties every stage; no result is presented until a new query arrives.
module segment_box_overlap_top #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] start_z,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    input  logic signed [COORD_WIDTH-1:0] end_z,
    input  logic signed [COORD_WIDTH-1:0] corner_a_x,
    input  logic signed [COORD_WIDTH-1:0] corner_a_y,
    input  logic signed [COORD_WIDTH-1:0] corner_a_z,
    input  logic signed [COORD_WIDTH-1:0] corner_b_x,
    input  logic signed [COORD_WIDTH-1:0] corner_b_y,
    input  logic signed [COORD_WIDTH-1:0] corner_b_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit
);
    import sbo_pkg::*;

    localparam int OW = COORD_WIDTH + 2;
    localparam int PW = 2 * OW;

    logic signed [COORD_WIDTH-1:0] s_in_w [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] e_in_w [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] ca_w   [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] cb_w   [NUM_AXES];
    logic signed [OW-1:0]          an_w   [NUM_AXES];
    logic signed [OW-1:0]          xn_w   [NUM_AXES];
    logic signed [OW-1:0]          dd_w   [NUM_AXES];
    lane_flags_t                   f1_w   [NUM_AXES];
    lane_flags_t                   f2_reg [NUM_AXES];
    lane_flags_t                   f3_reg [NUM_AXES];
    logic signed [PW-1:0]          pl_w   [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0]          pr_w   [NUM_AXES][NUM_AXES];

    logic v1_reg, v2_reg, v3_reg, out_valid_reg, hit_reg, hit_next;
    logic en1, en2, en3, en_out;
    logic all_s, all_e, stat_ok, ends_ok, pairs_ok;

    assign s_in_w = '{start_x, start_y, start_z};
    assign e_in_w = '{end_x, end_y, end_z};
    assign ca_w   = '{corner_a_x, corner_a_y, corner_a_z};
    assign cb_w   = '{corner_b_x, corner_b_y, corner_b_z};

    assign en_out   = !out_valid_reg || out_ready;
    assign en3      = !v3_reg || en_out;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    for (genvar k = 0; k < NUM_AXES; k++)
    begin : g_lane
        sbo_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane (
            .clk   (clk),
            .en    (en1),
            .s     (s_in_w[k]),
            .e     (e_in_w[k]),
            .ca    (ca_w[k]),
            .cb    (cb_w[k]),
            .an    (an_w[k]),
            .xn    (xn_w[k]),
            .dd    (dd_w[k]),
            .flags (f1_w[k])
        );
    end

    // Entry of axis i against exit of axis j: an_i * dd_j <= xn_j * dd_i.
    for (genvar i = 0; i < NUM_AXES; i++)
    begin : g_row
        for (genvar j = 0; j < NUM_AXES; j++)
        begin : g_col
            if (i != j)
            begin : g_pair
                sbo_mul #(.OW(OW)) u_mul_l (
                    .clk (clk), .en1 (en2), .en2 (en3),
                    .a (an_w[i]), .b (dd_w[j]), .p (pl_w[i][j])
                );
                sbo_mul #(.OW(OW)) u_mul_r (
                    .clk (clk), .en1 (en2), .en2 (en3),
                    .a (xn_w[j]), .b (dd_w[i]), .p (pr_w[i][j])
                );
            end
            else
            begin : g_diag
                assign pl_w[i][j] = '0;
                assign pr_w[i][j] = '0;
            end
        end
    end

    always_comb
    begin
        all_s    = 1'b1;
        all_e    = 1'b1;
        stat_ok  = 1'b1;
        ends_ok  = 1'b1;
        pairs_ok = 1'b1;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            all_s   = all_s && f3_reg[k].s_in;
            all_e   = all_e && f3_reg[k].e_in;
            stat_ok = stat_ok && (f3_reg[k].moving || f3_reg[k].s_in);
            ends_ok = ends_ok && (!f3_reg[k].moving
                                  || (f3_reg[k].en_lt1 && f3_reg[k].ex_gt0));
        end
        for (int i = 0; i < NUM_AXES; i++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                if (i != j && f3_reg[i].moving && f3_reg[j].moving
                    && (pl_w[i][j] > pr_w[i][j]))
                begin
                    pairs_ok = 1'b0;
                end
            end
        end
        hit_next = all_s || all_e || (stat_ok && ends_ok && pairs_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            f2_reg <= f1_w;
        end
        if (en3)
        begin
            f3_reg <= f2_reg;
        end
        if (en_out)
        begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    a_v3_held: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !en3) |=> v3_reg)
        else $error("stage three lost a beat while stalled");

    a_v1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en2) |=> v1_reg)
        else $error("stage one lost a beat while stalled");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v3_reg))
        else $error("result appeared without a beat in stage three");

endmodule
